[hdl/pag_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the attachment generator.
package pag_pkg;

   localparam int MAX_VERTICES = 65536;
   localparam int MAX_ATTACH   = 10;

   localparam int VTX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W    = VTX_W + 1;
   localparam int ATT_W    = $clog2(MAX_ATTACH + 1);
   localparam int DEG_W    = 16;
   localparam int TICKET_W = 24;
   localparam int WORD_W   = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(16);
   localparam logic [ATT_W-1:0] ATTACH_COUNT_RESET = ATT_W'(2);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DRAW  = 1'b1;

   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_ATTACH_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_EDGE   = 2'd0,
      ST_DONE   = 2'd1,
      ST_IDLE   = 2'd2,
      ST_BADCFG = 2'd3
   } status_type;

   typedef struct packed {
      logic take;
      logic status_emit;
      logic fill_write;
      logic clique_emit;
      logic mul;
      logic scan;
      logic update;
      logic edge_emit;
   } cmd_type;

   typedef struct packed {
      logic go_start;
      logic go_draw;
      logic fill_done;
      logic clique_last;
      logic scan_hit;
      logic out_free;
   } sts_type;

endpackage

[hdl/pag_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module pag_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pag_csr.sv]
// APB-style configuration registers for vertex and attachment counts.
module pag_csr import pag_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output logic [CNT_W-1:0]  vertex_count,
   output logic [ATT_W-1:0]  attach_count,
   output logic              cfg_write
);

   logic [CNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic [ATT_W-1:0] attach_count_ff, attach_count_in;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      attach_count_in = attach_count_ff;
      if (cfg_write) begin
         unique case (reg_sel)
            REG_VERTEX_COUNT: vertex_count_in = csr_pwdata[CNT_W-1:0];
            REG_ATTACH_COUNT: attach_count_in = csr_pwdata[ATT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_VERTEX_COUNT: csr_prdata = CSR_DW'(vertex_count_ff);
         REG_ATTACH_COUNT: csr_prdata = CSR_DW'(attach_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         attach_count_ff <= ATTACH_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
         attach_count_ff <= attach_count_in;
      end
   end

   assign vertex_count = vertex_count_ff;
   assign attach_count = attach_count_ff;

endmodule

[hdl/pag_ctrl.sv]
// Controller state machine sequencing start, draw and status transactions.
module pag_ctrl import pag_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_STATUS = 8'b0000_0010,
      S_FILL   = 8'b0000_0100,
      S_CLIQUE = 8'b0000_1000,
      S_MUL    = 8'b0001_0000,
      S_SCAN   = 8'b0010_0000,
      S_UPDATE = 8'b0100_0000,
      S_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (sts.go_start) begin
                  state_in = S_FILL;
               end else if (sts.go_draw) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_STATUS;
               end
            end
         end
         S_STATUS: begin
            if (sts.out_free) begin
               cmd.status_emit = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FILL: begin
            cmd.fill_write = 1'b1;
            if (sts.fill_done) begin
               state_in = S_CLIQUE;
            end
         end
         S_CLIQUE: begin
            if (sts.out_free) begin
               cmd.clique_emit = 1'b1;
               if (sts.clique_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.edge_emit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/pag_dp.sv]
// Datapath: graph state, ticket arithmetic, degree scan and result register.
module pag_dp import pag_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_type,
   input  logic [WORD_W-1:0] req_random_word,
   input  logic [CNT_W-1:0]  vertex_count,
   input  logic [ATT_W-1:0]  attach_count,
   input  logic              cfg_write,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [VTX_W-1:0]  rsp_edge_from,
   output logic [VTX_W-1:0]  rsp_edge_to,
   output logic              rsp_last,
   output logic [1:0]        rsp_status
);

   // Graph state.
   logic [CNT_W-1:0]    new_vertex_ff, new_vertex_in;
   logic [ATT_W-1:0]    draw_idx_ff, draw_idx_in;
   logic [TICKET_W-1:0] ticket_ff, ticket_in;
   logic [TICKET_W-1:0] round_ff, round_in;
   logic                started_ff, started_in;
   logic [VTX_W-1:0]    chosen_ff [MAX_ATTACH];
   logic [VTX_W-1:0]    chosen_in [MAX_ATTACH];

   // Transaction and scan working registers.
   logic [WORD_W-1:0]   word_ff, word_in;
   status_type          code_ff, code_in;
   logic [TICKET_W-1:0] s_ff, s_in;
   logic [CNT_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [VTX_W-1:0]    rd_vtx_ff, rd_vtx_in;
   logic                rd_chosen_ff, rd_chosen_in;
   logic [VTX_W-1:0]    pick_ff, pick_in;
   logic [DEG_W-1:0]    pick_raw_ff, pick_raw_in;
   logic [DEG_W-1:0]    pick_d_ff, pick_d_in;
   logic [ATT_W-1:0]    fill_ff, fill_in;
   logic [ATT_W-1:0]    ci_ff, ci_in;
   logic [ATT_W-1:0]    cj_ff, cj_in;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   logic [VTX_W-1:0]    out_from_ff, out_from_in;
   logic [VTX_W-1:0]    out_to_ff, out_to_in;
   logic                out_last_ff, out_last_in;
   status_type          out_status_ff, out_status_in;

   // Degree memory ports.
   logic                ram_we;
   logic [VTX_W-1:0]    ram_waddr;
   logic [DEG_W-1:0]    ram_wdata;
   logic [DEG_W-1:0]    ram_rdata;

   logic                   cfg_ok;
   logic [WORD_W+TICKET_W-1:0] product;
   logic                   issue_ok;
   logic                   addr_chosen;
   logic [DEG_W-1:0]       d_eff;
   logic [CNT_W-1:0]       nv_last;
   logic                   hit;
   logic                   round_end;
   logic [TICKET_W-1:0]    start_total;
   logic [TICKET_W-1:0]    grown_total;
   logic [ATT_W-1:0]       draw_next;

   pag_ram #(
      .WIDTH (DEG_W),
      .DEPTH (MAX_VERTICES)
   ) u_degree_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_addr_ff[VTX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign cfg_ok = (vertex_count >= CNT_W'(2)) && (vertex_count <= CNT_W'(MAX_VERTICES)) &&
                   (attach_count >= ATT_W'(1)) && (attach_count <= ATT_W'(MAX_ATTACH)) &&
                   (CNT_W'(attach_count) < vertex_count);

   // Decide what an offered transaction will do, from the state it finds.
   always_comb begin
      sts.go_start    = 1'b0;
      sts.go_draw     = 1'b0;
      sts.fill_done   = (fill_ff == attach_count);
      sts.clique_last = (ci_ff == attach_count - ATT_W'(1)) && (cj_ff == attach_count);
      sts.scan_hit    = cmd.scan && rd_valid_ff && hit;
      sts.out_free    = !out_valid_ff || rsp_ready;
      code_in         = code_ff;
      if (!cfg_ok) begin
         code_in = ST_BADCFG;
      end else if (req_type == REQ_START) begin
         sts.go_start = 1'b1;
      end else if (!started_ff) begin
         code_in = ST_IDLE;
      end else if (new_vertex_ff >= vertex_count) begin
         code_in = ST_DONE;
      end else begin
         sts.go_draw = 1'b1;
      end
      if (!cmd.take) begin
         code_in = code_ff;
      end
   end

   assign product   = {{TICKET_W{1'b0}}, word_ff} * {{WORD_W{1'b0}}, round_ff};
   assign issue_ok  = scan_addr_ff < new_vertex_ff;
   assign d_eff     = rd_chosen_ff ? '0 : ram_rdata;
   assign nv_last   = new_vertex_ff - CNT_W'(1);
   // The last vertex below the new one is taken even if the ticket never went negative.
   assign hit       = (s_ff < TICKET_W'(d_eff)) || ({1'b0, rd_vtx_ff} == nv_last);
   assign draw_next = draw_idx_ff + ATT_W'(1);
   assign round_end = draw_next >= attach_count;
   assign start_total = TICKET_W'(attach_count) * TICKET_W'(attach_count + ATT_W'(1));
   assign grown_total = ticket_ff + TICKET_W'({attach_count, 1'b0});

   always_comb begin
      addr_chosen = 1'b0;
      for (int i = 0; i < MAX_ATTACH; i++) begin
         if ((ATT_W'(i) < draw_idx_ff) && (chosen_ff[i] == scan_addr_ff[VTX_W-1:0])) begin
            addr_chosen = 1'b1;
         end
      end
   end

   always_comb begin
      word_in      = word_ff;
      new_vertex_in = new_vertex_ff;
      draw_idx_in  = draw_idx_ff;
      ticket_in    = ticket_ff;
      round_in     = round_ff;
      started_in   = started_ff;
      chosen_in    = chosen_ff;
      s_in         = s_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = 1'b0;
      rd_vtx_in    = scan_addr_ff[VTX_W-1:0];
      rd_chosen_in = addr_chosen;
      pick_in      = pick_ff;
      pick_raw_in  = pick_raw_ff;
      pick_d_in    = pick_d_ff;
      fill_in      = fill_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      ram_we       = 1'b0;
      ram_waddr    = pick_ff;
      ram_wdata    = pick_raw_ff + DEG_W'(1);

      if (cmd.take) begin
         word_in = req_random_word;
         fill_in = '0;
         ci_in   = '0;
         cj_in   = ATT_W'(1);
      end

      if (cmd.fill_write) begin
         ram_we    = 1'b1;
         ram_waddr = VTX_W'(fill_ff);
         ram_wdata = DEG_W'(attach_count);
         fill_in   = fill_ff + ATT_W'(1);
      end

      if (cmd.clique_emit) begin
         if (cj_ff == attach_count) begin
            ci_in = ci_ff + ATT_W'(1);
            cj_in = ci_ff + ATT_W'(2);
         end else begin
            cj_in = cj_ff + ATT_W'(1);
         end
         if (sts.clique_last) begin
            new_vertex_in = CNT_W'(attach_count) + CNT_W'(1);
            draw_idx_in   = '0;
            ticket_in     = start_total;
            round_in      = start_total;
            started_in    = 1'b1;
         end
      end

      if (cmd.mul) begin
         s_in         = product[WORD_W+TICKET_W-1:WORD_W];
         scan_addr_in = '0;
      end

      // Reads are issued one vertex a cycle; each result is judged in the cycle after its read.
      if (cmd.scan) begin
         scan_addr_in = scan_addr_ff + CNT_W'(1);
         rd_valid_in  = issue_ok && !sts.scan_hit;
         if (rd_valid_ff) begin
            if (hit) begin
               pick_in     = rd_vtx_ff;
               pick_raw_in = ram_rdata;
               pick_d_in   = d_eff;
            end else begin
               s_in = s_ff - TICKET_W'(d_eff);
            end
         end
      end

      if (cmd.update) begin
         ram_we    = 1'b1;
         ram_waddr = pick_ff;
         ram_wdata = pick_raw_ff + DEG_W'(1);
         round_in  = (round_ff >= TICKET_W'(pick_d_ff)) ? round_ff - TICKET_W'(pick_d_ff) : '0;
         if (draw_idx_ff < ATT_W'(MAX_ATTACH)) begin
            chosen_in[draw_idx_ff] = pick_ff;
         end
      end

      if (cmd.edge_emit) begin
         if (round_end) begin
            ram_we        = 1'b1;
            ram_waddr     = new_vertex_ff[VTX_W-1:0];
            ram_wdata     = DEG_W'(attach_count);
            ticket_in     = grown_total;
            round_in      = grown_total;
            draw_idx_in   = '0;
            new_vertex_in = new_vertex_ff + CNT_W'(1);
         end else begin
            draw_idx_in = draw_next;
         end
      end

      // Changing the configuration abandons any graph in progress.
      if (cfg_write) begin
         started_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_from_in   = out_from_ff;
      out_to_in     = out_to_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (cmd.status_emit) begin
         out_valid_in  = 1'b1;
         out_from_in   = '0;
         out_to_in     = '0;
         out_last_in   = 1'b1;
         out_status_in = code_ff;
      end else if (cmd.clique_emit) begin
         out_valid_in  = 1'b1;
         out_from_in   = VTX_W'(ci_ff);
         out_to_in     = VTX_W'(cj_ff);
         out_last_in   = sts.clique_last;
         out_status_in = ST_EDGE;
      end else if (cmd.edge_emit) begin
         out_valid_in  = 1'b1;
         out_from_in   = new_vertex_ff[VTX_W-1:0];
         out_to_in     = pick_ff;
         out_last_in   = 1'b1;
         out_status_in = ST_EDGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_vertex_ff <= '0;
         draw_idx_ff   <= '0;
         ticket_ff     <= '0;
         round_ff      <= '0;
         started_ff    <= 1'b0;
         rd_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         code_ff       <= ST_EDGE;
      end else begin
         new_vertex_ff <= new_vertex_in;
         draw_idx_ff   <= draw_idx_in;
         ticket_ff     <= ticket_in;
         round_ff      <= round_in;
         started_ff    <= started_in;
         rd_valid_ff   <= rd_valid_in;
         out_valid_ff  <= out_valid_in;
         code_ff       <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      chosen_ff     <= chosen_in;
      word_ff       <= word_in;
      s_ff          <= s_in;
      scan_addr_ff  <= scan_addr_in;
      rd_vtx_ff     <= rd_vtx_in;
      rd_chosen_ff  <= rd_chosen_in;
      pick_ff       <= pick_in;
      pick_raw_ff   <= pick_raw_in;
      pick_d_ff     <= pick_d_in;
      fill_ff       <= fill_in;
      ci_ff         <= ci_in;
      cj_ff         <= cj_in;
      out_from_ff   <= out_from_in;
      out_to_ff     <= out_to_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_edge_from = out_from_ff;
   assign rsp_edge_to   = out_to_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_status    = out_status_ff;

endmodule

[hdl/preferential_attachment_generator_core.sv]
// Top level of the preferential-attachment graph generator.
// One transaction is taken at a time. A start transaction writes the degrees of the initial
// clique and then emits one clique edge per cycle while the result side keeps up. A draw
// transaction multiplies for the ticket, then reads one degree entry per cycle from the read
// port of the degree memory until the chosen vertex is found, then writes its new degree and
// presents the edge. The degree memory is not cleared after reset; a start fills the entries of
// the clique and each finished round fills the entry of its new vertex before draws read it.
// A result waits in an output register, so the next transaction is accepted while it is still
// pending.
module preferential_attachment_generator_core import pag_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [WORD_W-1:0] req_random_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [VTX_W-1:0]  rsp_edge_from,
   output logic [VTX_W-1:0]  rsp_edge_to,
   output logic              rsp_last,
   output logic [1:0]        rsp_status,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cmd_type          cmd;
   sts_type          sts;
   logic [CNT_W-1:0] vertex_count;
   logic [ATT_W-1:0] attach_count;
   logic             cfg_write;

   pag_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count),
      .attach_count (attach_count),
      .cfg_write    (cfg_write)
   );

   pag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pag_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_random_word (req_random_word),
      .vertex_count    (vertex_count),
      .attach_count    (attach_count),
      .cfg_write       (cfg_write),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_from   (rsp_edge_from),
      .rsp_edge_to     (rsp_edge_to),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.status_emit || cmd.clique_emit || cmd.edge_emit) |-> sts.out_free)
      else $error("result loaded while output register busy");

   // The controller issues at most one command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.status_emit, cmd.fill_write, cmd.clique_emit,
                cmd.mul, cmd.scan, cmd.update, cmd.edge_emit}))
      else $error("conflicting datapath commands");

   // After a transaction is accepted the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted back to back");

   // A scan can only finish while a scan is in progress.
   assert property (@(posedge clock) disable iff (reset)
      sts.scan_hit |-> cmd.scan)
      else $error("scan hit reported outside a scan");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the preferential-attachment graph generator core.
module testbench;
   import pag_pkg::*;

   typedef struct packed {
      logic [VTX_W-1:0] edge_src;
      logic [VTX_W-1:0] edge_dst;
      logic             last;
      status_type       status;
   } edge_result_type;

   typedef struct {
      bit                 is_csr;
      logic [CSR_AW-1:0]  addr;
      logic [CSR_DW-1:0]  data;
      logic               rtype;
      logic [WORD_W-1:0]  word;
      bit                 typed;
      edge_result_type    known;
   } stim_row_type;

   typedef enum int {RX_STEADY, RX_JITTER, RX_SLUGGISH} ready_pattern_type;

   localparam logic [CSR_AW-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_ATTACH_COUNT = {REG_ATTACH_COUNT, 2'b00};
   localparam int RANDOM_REQUESTS = 75;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_type = REQ_START;
   logic [WORD_W-1:0] req_random_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [VTX_W-1:0]  rsp_edge_from;
   logic [VTX_W-1:0]  rsp_edge_to;
   logic              rsp_last;
   logic [1:0]        rsp_status;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   preferential_attachment_generator_core dut (.*);

   always #2 clock = ~clock;

   // Shadow copy of the generator state.
   logic [CNT_W-1:0]    cfg_vertices = VERTEX_COUNT_RESET;
   logic [ATT_W-1:0]    cfg_attach = ATTACH_COUNT_RESET;
   logic [DEG_W-1:0]    degrees [0:MAX_VERTICES-1];
   logic [VTX_W-1:0]    picked [0:MAX_ATTACH-1];
   int unsigned         next_vertex = 0;
   int unsigned         draws_done = 0;
   logic [TICKET_W-1:0] tickets_total = '0;
   logic [TICKET_W-1:0] round_left = '0;
   bit                  graph_started = 1'b0;

   edge_result_type   step_edges[$];
   edge_result_type   expected_edges[$];
   edge_result_type   oldest;
   stim_row_type      directed_rows[$];
   int                fault_count = 0;
   int                requests_sent = 0;
   int                burst_left = 0;
   ready_pattern_type rx_pattern = RX_STEADY;
   int                rx_left = 0;

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= 10) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic bit config_valid();
      return cfg_vertices >= 2 && cfg_vertices <= MAX_VERTICES && cfg_attach >= 1 &&
             cfg_attach <= MAX_ATTACH && cfg_attach < cfg_vertices;
   endfunction

   function automatic bit was_picked(input int unsigned v);
      for (int i = 0; i < draws_done && i < MAX_ATTACH; i++)
         if (picked[i] == VTX_W'(v)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic edge_result_type status_result(input status_type code);
      return '{'0, '0, 1'b1, code};
   endfunction

   // Works out the results of one transaction and moves the shadow state on.
   task automatic predict_request(input logic rtype, input logic [WORD_W-1:0] word);
      int unsigned k;
      int unsigned pick;
      logic [DEG_W-1:0] deg;
      logic [63:0] product;
      longint ticket;
      bit hit;
      step_edges.delete();
      k = cfg_attach;
      if (!config_valid()) begin
         step_edges.push_back(status_result(ST_BADCFG));
      end else if (rtype == REQ_START) begin
         for (int unsigned i = 0; i <= k; i++) degrees[i] = DEG_W'(k);
         for (int unsigned i = 0; i <= k; i++)
            for (int unsigned j = i + 1; j <= k; j++)
               step_edges.push_back('{VTX_W'(i), VTX_W'(j), (i == k - 1), ST_EDGE});
         next_vertex = k + 1;
         draws_done = 0;
         tickets_total = TICKET_W'(k * (k + 1));
         round_left = tickets_total;
         graph_started = 1'b1;
      end else if (!graph_started) begin
         step_edges.push_back(status_result(ST_IDLE));
      end else if (next_vertex >= cfg_vertices) begin
         step_edges.push_back(status_result(ST_DONE));
      end else begin
         // Roulette wheel: vertices already taken this round hold no tickets.
         product = {32'd0, word} * {40'd0, round_left};
         ticket = product[63:32];
         hit = 1'b0;
         pick = 0;
         for (int unsigned v = 0; v < next_vertex && v < MAX_VERTICES && !hit; v++) begin
            pick = v;
            deg = was_picked(v) ? '0 : degrees[v];
            ticket = ticket - deg;
            if (ticket < 0) hit = 1'b1;
         end
         deg = was_picked(pick) ? '0 : degrees[pick];
         round_left = (round_left >= deg) ? round_left - deg : '0;
         degrees[pick] = degrees[pick] + 1'b1;
         if (draws_done < MAX_ATTACH) picked[draws_done] = VTX_W'(pick);
         step_edges.push_back('{VTX_W'(next_vertex), VTX_W'(pick), 1'b1, ST_EDGE});
         draws_done++;
         if (draws_done >= k) begin
            if (next_vertex < MAX_VERTICES) degrees[next_vertex] = DEG_W'(k);
            tickets_total = tickets_total + TICKET_W'(2 * k);
            round_left = tickets_total;
            draws_done = 0;
            next_vertex++;
         end
      end
   endtask

   // Presents one request, in bursts with random gaps, and records its results once taken.
   task automatic send_request(input logic rtype, input logic [WORD_W-1:0] word,
                               input bit typed, input edge_result_type known);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= rtype;
      req_random_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(rtype, word);
      if (typed) expected_edges.push_back(known);
      else foreach (step_edges[i]) expected_edges.push_back(step_edges[i]);
      requests_sent++;
   endtask

   // Writes a register once the block has drained, then reads it back.
   task automatic program_register(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] held;
      logic [CSR_DW-1:0] want;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      held = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_VERTEX_COUNT) begin
         cfg_vertices = value[CNT_W-1:0];
         want = CSR_DW'(value[CNT_W-1:0]);
      end else begin
         cfg_attach = value[ATT_W-1:0];
         want = CSR_DW'(value[ATT_W-1:0]);
      end
      graph_started = 1'b0;
      if (held !== want)
         note_fault($sformatf("register %0d read back %0h, wrote %0h", addr, held, want));
   endtask

   task automatic add_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      directed_rows.push_back('{1'b1, addr, value, REQ_START, '0, 1'b0, '0});
   endtask

   task automatic add_request(input logic rtype, input logic [WORD_W-1:0] word);
      directed_rows.push_back('{1'b0, '0, '0, rtype, word, 1'b0, '0});
   endtask

   task automatic add_known(input logic rtype, input logic [WORD_W-1:0] word,
                            input edge_result_type known);
      directed_rows.push_back('{1'b0, '0, '0, rtype, word, 1'b1, known});
   endtask

   // The receiver switches between steady, jittery and sluggish acceptance.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_pattern <= ready_pattern_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(20, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_pattern)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_JITTER: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_edges.size() == 0) begin
            note_fault($sformatf("unexpected result %0d-%0d last %0b status %0d",
                                 rsp_edge_from, rsp_edge_to, rsp_last, rsp_status));
         end else begin
            oldest = expected_edges.pop_front();
            if (rsp_edge_from !== oldest.edge_src || rsp_edge_to !== oldest.edge_dst ||
                rsp_last !== oldest.last || rsp_status !== oldest.status)
               note_fault($sformatf({"expected %0d-%0d last %0b status %0d, ",
                                     "got %0d-%0d last %0b status %0d"},
                                    oldest.edge_src, oldest.edge_dst, oldest.last, oldest.status,
                                    rsp_edge_from, rsp_edge_to, rsp_last, rsp_status));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int target;
      int draws;
      int unsigned n;
      int unsigned k;
      logic [WORD_W-1:0] word;

      // Reset values first, then each error code, the clique at its largest and a full round.
      add_known(REQ_DRAW, 32'h1234_5678, status_result(ST_IDLE));
      add_request(REQ_START, '0);
      add_known(REQ_DRAW, 32'h0000_0000, '{16'd3, 16'd0, 1'b1, ST_EDGE});
      add_request(REQ_DRAW, 32'hFFFF_FFFF);
      add_csr(ADDR_VERTEX_COUNT, 32'd0);
      add_known(REQ_DRAW, 32'h0, status_result(ST_BADCFG));
      add_csr(ADDR_VERTEX_COUNT, 32'd1);
      add_known(REQ_DRAW, 32'h0, status_result(ST_BADCFG));
      add_csr(ADDR_VERTEX_COUNT, 32'd2);
      add_csr(ADDR_ATTACH_COUNT, 32'd1);
      add_known(REQ_DRAW, 32'h0, status_result(ST_IDLE));
      add_request(REQ_START, '0);
      add_known(REQ_DRAW, 32'hFFFF_FFFF, status_result(ST_DONE));
      add_csr(ADDR_ATTACH_COUNT, 32'd0);
      add_known(REQ_START, '0, status_result(ST_BADCFG));
      add_csr(ADDR_ATTACH_COUNT, 32'd2);
      add_known(REQ_DRAW, 32'h0, status_result(ST_BADCFG));
      add_csr(ADDR_ATTACH_COUNT, 32'hFFFF_FFFF);
      add_known(REQ_DRAW, 32'h0, status_result(ST_BADCFG));
      add_csr(ADDR_VERTEX_COUNT, 32'd131071);
      add_csr(ADDR_ATTACH_COUNT, 32'd10);
      add_known(REQ_START, '0, status_result(ST_BADCFG));
      add_csr(ADDR_VERTEX_COUNT, 32'd65536);
      add_request(REQ_START, '0);
      add_request(REQ_DRAW, 32'h0000_0000);
      add_request(REQ_DRAW, 32'hFFFF_FFFF);
      add_request(REQ_DRAW, 32'h8000_0000);
      add_request(REQ_DRAW, 32'h5555_5555);
      add_request(REQ_DRAW, 32'hAAAA_AAAA);
      add_request(REQ_DRAW, 32'h0000_0001);
      add_request(REQ_DRAW, 32'hFFFF_FFFE);
      add_request(REQ_DRAW, 32'h7FFF_FFFF);
      add_request(REQ_DRAW, 32'h3C3C_C3C3);
      add_request(REQ_DRAW, 32'hC000_0000);
      add_request(REQ_DRAW, 32'h0000_0000);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            program_register(directed_rows[i].addr, directed_rows[i].data);
         else
            send_request(directed_rows[i].rtype, directed_rows[i].word,
                         directed_rows[i].typed, directed_rows[i].known);
      end

      // Random graphs: mostly small valid ones, now and then an invalid setting.
      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
               0: begin n = $urandom_range(0, 1); k = $urandom_range(1, 10); end
               1: begin n = $urandom_range(65537, 131071); k = $urandom_range(1, 10); end
               2: begin n = $urandom_range(2, 40); k = 0; end
               3: begin n = $urandom_range(12, 40); k = $urandom_range(11, 15); end
               default: begin k = $urandom_range(2, 10); n = $urandom_range(2, k); end
            endcase
         end else begin
            k = $urandom_range(1, 10);
            if ($urandom_range(0, 7) == 0) n = MAX_VERTICES;
            else n = k + 1 + $urandom_range(0, $urandom_range(0, 1) ? 4 : 40);
         end
         if ($urandom_range(0, 1)) begin
            program_register(ADDR_VERTEX_COUNT, n);
            program_register(ADDR_ATTACH_COUNT, k);
         end else begin
            program_register(ADDR_ATTACH_COUNT, k);
            program_register(ADDR_VERTEX_COUNT, n);
         end
         if ($urandom_range(0, 7) == 0) send_request(REQ_DRAW, $urandom, 1'b0, '0);
         send_request(REQ_START, $urandom, 1'b0, '0);
         draws = $urandom_range(1, 25);
         for (int d = 0; d < draws && requests_sent < target; d++) begin
            case ($urandom_range(0, 9))
               0: word = '0;
               1: word = '1;
               default: word = $urandom;
            endcase
            if ($urandom_range(0, 11) == 0) send_request(REQ_START, word, 1'b0, '0);
            else send_request(REQ_DRAW, word, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fault_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

[preferential_attachment_generator_core.f]
hdl/pag_pkg.sv
hdl/pag_ram.sv
hdl/pag_csr.sv
hdl/pag_ctrl.sv
hdl/pag_dp.sv
hdl/preferential_attachment_generator_core.sv
tb/sv/testbench.sv
